FILE: rtl/palt_pkg.sv
`timescale 1ns / 1ps

package palt_pkg;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int unsigned TINT_RED_LAST  = 8;
    localparam int unsigned TINT_GOLD_LAST = 12;

    typedef struct packed {
        logic       kind;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_word;

    typedef struct packed {
        logic [15:0] color565;
        logic [7:0]  match_index;
    } t_out_word;

    // blend targets need 9 bits: green tint aims at 256
    typedef struct packed {
        logic [8:0] r;
        logic [8:0] g;
        logic [8:0] b;
    } t_rgb9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_SCAN,
        ST_DONE
    } t_state;

    // 16-bit blend fraction per tint number, n*65536/9 truncated for red
    function automatic logic [16:0] tint_mul(input logic [3:0] n);
        logic [16:0] m;
        unique case (n)
            4'd0:    m = 17'd0;
            4'd1:    m = 17'd7281;
            4'd2:    m = 17'd14563;
            4'd3:    m = 17'd21845;
            4'd4:    m = 17'd29127;
            4'd5:    m = 17'd36408;
            4'd6:    m = 17'd43690;
            4'd7:    m = 17'd50972;
            4'd8:    m = 17'd58254;
            4'd9:    m = 17'd8192;
            4'd10:   m = 17'd16384;
            4'd11:   m = 17'd24576;
            4'd12:   m = 17'd32768;
            default: m = 17'd8192;
        endcase
        return m;
    endfunction

    function automatic t_rgb9 tint_target(input logic [3:0] n);
        t_rgb9 t;
        if (n == 4'd0) begin
            t = '{r: 9'd0, g: 9'd0, b: 9'd0};
        end else if (n <= 4'(TINT_RED_LAST)) begin
            t = '{r: 9'd255, g: 9'd0, b: 9'd0};
        end else if (n <= 4'(TINT_GOLD_LAST)) begin
            t = '{r: 9'd215, g: 9'd186, b: 9'd69};
        end else begin
            t = '{r: 9'd0, g: 9'd256, b: 9'd0};
        end
        return t;
    endfunction

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

FILE: rtl/palette_tint_and_nearest_match.sv
`timescale 1ns / 1ps
// load: after accept ST_MUL and ST_WB, then ST_DONE loads the result; the next word is taken in ST_IDLE
// query: after accept ST_SCAN until the last compare, then ST_DONE and ST_IDLE as for a load;
//   the scan reads one palette entry per cycle through the single read port of the ram
// one word is in work at a time; a finished result waits in the output register
// reset (synchronous, active low) clears control, tint to 0 and all entry valid bits
//   at once, so every entry reads as black until loaded; no clearing pass
module palette_tint_and_nearest_match #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  palt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output palt_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_data
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    palt_pkg::t_state r_state, n_state;
    logic             w_accept;
    logic             w_out_load;

    logic [3:0]          r_tint;
    palt_pkg::t_in_word  r_in;
    palt_pkg::t_out_word r_res;
    logic                r_out_valid;
    palt_pkg::t_out_word r_out_word;

    logic [PALETTE_ENTRIES-1:0] r_valid;

    // tint datapath
    palt_pkg::t_rgb9     w_tgt;
    logic signed [17:0]  w_mul;
    logic signed [9:0]   w_dr, w_dg, w_db;
    logic signed [27:0]  w_tr, w_tg, w_tb;
    logic [7:0]          r_qr, r_qg, r_qb;
    logic [7:0]          w_nr, w_ng, w_nb;
    logic                w_in_range;
    logic                w_we;

    // scan datapath
    logic [IDX_W-1:0]   r_scan_addr;
    logic               r_issue;
    logic               r_s1_vld, r_s1_last, r_rd_valid;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [23:0]        w_rdata;
    logic [23:0]        w_entry;
    logic signed [8:0]  w_er, w_eg, w_eb;
    logic signed [17:0] w_sr, w_sg, w_sb;
    logic               r_s2_vld, r_s2_last;
    logic [IDX_W-1:0]   r_s2_idx;
    logic [15:0]        r_sq_r, r_sq_g, r_sq_b;
    logic [17:0]        w_sum;
    logic               w_better;
    logic [17:0]        r_best_diff;
    logic [IDX_W-1:0]   r_best_idx;

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= palt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            palt_pkg::ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    n_state = (i_in_word.kind == palt_pkg::KIND_QUERY) ?
                              palt_pkg::ST_SCAN : palt_pkg::ST_MUL;
                end
            end
            palt_pkg::ST_MUL: n_state = palt_pkg::ST_WB;
            palt_pkg::ST_WB:  n_state = palt_pkg::ST_DONE;
            palt_pkg::ST_SCAN: begin
                if (r_s2_vld && r_s2_last) begin
                    n_state = palt_pkg::ST_DONE;
                end
            end
            palt_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = palt_pkg::ST_IDLE;
                end
            end
            default: n_state = palt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint <= 4'd0;
        end else if (i_cfg_we) begin
            r_tint <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_word;
        end
    end

    // tint: c + floor((target - c) * mul / 65536), only the low byte survives
    assign w_tgt = palt_pkg::tint_target(r_tint);
    assign w_mul = $signed({1'b0, palt_pkg::tint_mul(r_tint)});
    assign w_dr  = $signed({1'b0, w_tgt.r}) - $signed({2'b00, r_in.red});
    assign w_dg  = $signed({1'b0, w_tgt.g}) - $signed({2'b00, r_in.green});
    assign w_db  = $signed({1'b0, w_tgt.b}) - $signed({2'b00, r_in.blue});
    assign w_tr  = w_dr * w_mul;
    assign w_tg  = w_dg * w_mul;
    assign w_tb  = w_db * w_mul;

    always_ff @(posedge i_clk) begin
        if (r_state == palt_pkg::ST_MUL) begin
            r_qr <= w_tr[23:16];
            r_qg <= w_tg[23:16];
            r_qb <= w_tb[23:16];
        end
    end

    assign w_nr       = r_in.red + r_qr;
    assign w_ng       = r_in.green + r_qg;
    assign w_nb       = r_in.blue + r_qb;
    assign w_in_range = {1'b0, r_in.entry_index} < 9'(PALETTE_ENTRIES);
    assign w_we       = (r_state == palt_pkg::ST_WB) && w_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[r_in.entry_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    palt_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_in.entry_index[IDX_W-1:0]),
        .i_wdata ({w_nr, w_ng, w_nb}),
        .i_raddr (r_scan_addr),
        .o_rdata (w_rdata)
    );

    // scan pipeline: read issue, squares, sum and compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue  <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_accept && i_in_word.kind == palt_pkg::KIND_QUERY) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_scan_addr == LAST_IDX) begin
                r_issue <= 1'b0;
            end
            r_s1_vld <= r_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scan_addr <= '0;
        end else if (r_issue && r_scan_addr != LAST_IDX) begin
            r_scan_addr <= r_scan_addr + 1'b1;
        end
        r_rd_valid <= r_valid[r_scan_addr];
        r_s1_idx   <= r_scan_addr;
        r_s1_last  <= r_scan_addr == LAST_IDX;
    end

    // an entry never loaded reads as black
    assign w_entry = r_rd_valid ? w_rdata : 24'd0;
    assign w_er    = $signed({1'b0, r_in.red})   - $signed({1'b0, w_entry[23:16]});
    assign w_eg    = $signed({1'b0, r_in.green}) - $signed({1'b0, w_entry[15:8]});
    assign w_eb    = $signed({1'b0, r_in.blue})  - $signed({1'b0, w_entry[7:0]});
    assign w_sr    = w_er * w_er;
    assign w_sg    = w_eg * w_eg;
    assign w_sb    = w_eb * w_eb;

    always_ff @(posedge i_clk) begin
        r_sq_r    <= w_sr[15:0];
        r_sq_g    <= w_sg[15:0];
        r_sq_b    <= w_sb[15:0];
        r_s2_idx  <= r_s1_idx;
        r_s2_last <= r_s1_last;
    end

    // max distance is below the all-ones start value, so entry 0 always wins first
    assign w_sum    = {2'b00, r_sq_r} + {2'b00, r_sq_g} + {2'b00, r_sq_b};
    assign w_better = w_sum < r_best_diff;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_best_diff <= '1;
            r_best_idx  <= '0;
        end else if (r_s2_vld && w_better) begin
            r_best_diff <= w_sum;
            r_best_idx  <= r_s2_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == palt_pkg::ST_WB) begin
            r_res.color565    <= palt_pkg::pack565(w_nr, w_ng, w_nb);
            r_res.match_index <= 8'd0;
        end else if (r_s2_vld && r_s2_last) begin
            r_res.color565    <= 16'd0;
            r_res.match_index <= w_better ? 8'(r_s2_idx) : 8'(r_best_idx);
        end
    end

    // output register parts the result from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == palt_pkg::ST_IDLE |-> !r_issue && !r_s1_vld && !r_s2_vld)
        else $error("scan pipeline busy while idle");

    a_write_in_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_state == palt_pkg::ST_WB && r_in.kind == palt_pkg::KIND_LOAD)
        else $error("palette written outside a load");

    a_scan_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld && r_s2_last |=> r_state == palt_pkg::ST_DONE)
        else $error("last compare did not finish the query");

    a_load_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == palt_pkg::ST_DONE && r_in.kind == palt_pkg::KIND_LOAD
        |-> r_res.match_index == 8'd0)
        else $error("load result carries a match index");

endmodule

FILE: rtl/palt_ram.sv
`timescale 1ns / 1ps

module palt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
